@@ hw/rtl/tlh_pkg.sv @@
// Package for the task latency histogram block.
// Holds payload structs, opcode/kind/register codes and inter-module structs.
// No dependencies.
package tlh_pkg;

  localparam int unsigned ID_W       = 22;
  localparam int unsigned KEY_W      = 2 * ID_W;
  localparam int unsigned TS_W       = 64;
  localparam int unsigned IDX_MAX_W  = 16;
  localparam int unsigned SLOT_MAX_W = 6;

  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_END   = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  localparam logic [1:0] KIND_NONE  = 2'd0;
  localparam logic [1:0] KIND_EVENT = 2'd1;
  localparam logic [1:0] KIND_SLOT  = 2'd2;
  localparam logic [1:0] KIND_BAD   = 2'd3;

  localparam logic [1:0] CFG_GROUP  = 2'd0;
  localparam logic [1:0] CFG_TASK   = 2'd1;
  localparam logic [1:0] CFG_THRESH = 2'd2;

  typedef struct packed {
    logic [1:0]      opcode;
    logic [ID_W-1:0] group_id;
    logic [ID_W-1:0] task_id;
    logic [TS_W-1:0] now_ns;
    logic [4:0]      slot_select;
  } in_t;

  typedef struct packed {
    logic [1:0]      report_kind;
    logic [ID_W-1:0] report_task;
    logic [TS_W-1:0] report_end_ns;
    logic [TS_W-1:0] report_latency;
    logic [31:0]     slot_hits;
    logic [TS_W-1:0] slot_sum_ns;
  } out_t;

  typedef struct packed {
    logic             go;
    logic [KEY_W-1:0] key;
  } tab_req_t;

  typedef struct packed {
    logic                 we;
    logic                 clr;
    logic [IDX_MAX_W-1:0] idx;
    logic [KEY_W-1:0]     key;
    logic [TS_W-1:0]      ns;
  } tab_wr_t;

  typedef struct packed {
    logic                 done;
    logic                 hit;
    logic                 free_ok;
    logic [IDX_MAX_W-1:0] idx;
    logic [TS_W-1:0]      start_ns;
  } tab_resp_t;

  typedef struct packed {
    logic                  rd_en;
    logic [SLOT_MAX_W-1:0] rd_idx;
    logic                  we;
    logic [SLOT_MAX_W-1:0] wr_idx;
    logic [31:0]           hits;
    logic [TS_W-1:0]       sum;
  } hist_req_t;

  typedef struct packed {
    logic [31:0]     hits;
    logic [TS_W-1:0] sum;
  } hist_resp_t;

endpackage

@@ hw/rtl/tlh_table.sv @@
// Task table: key/start-time memory with per-entry valid flops and a
// sequential scan engine for key lookup and lowest free entry.
// Depends on tlh_pkg.
module tlh_table #(
  parameter int unsigned ENTRIES = 256
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tlh_pkg::tab_req_t  req_i,
  input  tlh_pkg::tab_wr_t   wr_i,
  output tlh_pkg::tab_resp_t resp_o
);
  import tlh_pkg::*;

  localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CW = $clog2(ENTRIES + 1);
  localparam int unsigned DW = KEY_W + TS_W;

  logic [ENTRIES-1:0] valid_q;
  logic [DW-1:0]      mem [ENTRIES];
  logic [DW-1:0]      rdata_q;
  logic               busy_q;
  logic [CW-1:0]      cnt_q;
  logic               chk_q;
  logic [IW-1:0]      chk_idx_q;
  logic               chk_vld_q;
  logic               free_q;
  logic [IW-1:0]      free_idx_q;
  logic [KEY_W-1:0]   key_q;

  logic          issue;
  logic [IW-1:0] rd_idx;
  logic          match;
  logic          last;
  logic          done;
  logic          cur_free;

  assign issue    = busy_q && (cnt_q < CW'(ENTRIES));
  assign rd_idx   = cnt_q[IW-1:0];
  assign match    = chk_q && chk_vld_q && (rdata_q[DW-1:TS_W] == key_q);
  assign last     = (chk_idx_q == IW'(ENTRIES - 1));
  assign done     = chk_q && (match || last);
  assign cur_free = chk_q && !chk_vld_q;

  always_comb begin
    resp_o.done     = done;
    resp_o.hit      = match;
    resp_o.free_ok  = free_q || cur_free;
    resp_o.idx      = IDX_MAX_W'(match ? chk_idx_q : (free_q ? free_idx_q : chk_idx_q));
    resp_o.start_ns = rdata_q[TS_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q     <= 1'b0;
      cnt_q      <= '0;
      chk_q      <= 1'b0;
      chk_idx_q  <= '0;
      chk_vld_q  <= 1'b0;
      free_q     <= 1'b0;
      free_idx_q <= '0;
      key_q      <= '0;
      valid_q    <= '0;
    end else begin
      if (req_i.go) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        chk_q  <= 1'b0;
        free_q <= 1'b0;
        key_q  <= req_i.key;
      end else begin
        chk_q <= issue;
        if (issue) begin
          cnt_q     <= cnt_q + 1'b1;
          chk_idx_q <= rd_idx;
          chk_vld_q <= valid_q[rd_idx];
        end
        if (cur_free && !free_q) begin
          free_q     <= 1'b1;
          free_idx_q <= chk_idx_q;
        end
        if (done) begin
          busy_q <= 1'b0;
          chk_q  <= 1'b0;
        end
      end
      if (wr_i.we) valid_q[wr_i.idx[IW-1:0]] <= 1'b1;
      if (wr_i.clr) valid_q[wr_i.idx[IW-1:0]] <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.we) mem[wr_i.idx[IW-1:0]] <= {wr_i.key, wr_i.ns};
    if (issue) rdata_q <= mem[rd_idx];
  end

endmodule

@@ hw/rtl/tlh_hist.sv @@
// Histogram store: per-slot count and total in a synchronous memory,
// with per-slot valid flops so unwritten slots read as zero.
// Depends on tlh_pkg.
module tlh_hist #(
  parameter int unsigned SLOTS = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tlh_pkg::hist_req_t  req_i,
  output tlh_pkg::hist_resp_t resp_o
);
  import tlh_pkg::*;

  localparam int unsigned SW = $clog2(SLOTS);

  logic [SLOTS-1:0]  valid_q;
  logic [31+TS_W:0]  mem [SLOTS];
  logic [31+TS_W:0]  rdata_q;
  logic              rvld_q;

  assign resp_o.hits = rvld_q ? rdata_q[31+TS_W:TS_W] : 32'd0;
  assign resp_o.sum  = rvld_q ? rdata_q[TS_W-1:0] : {TS_W{1'b0}};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      rvld_q  <= 1'b0;
    end else begin
      if (req_i.rd_en) rvld_q <= valid_q[req_i.rd_idx[SW-1:0]];
      if (req_i.we) valid_q[req_i.wr_idx[SW-1:0]] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.we) mem[req_i.wr_idx[SW-1:0]] <= {req_i.hits, req_i.sum};
    if (req_i.rd_en) rdata_q <= mem[req_i.rd_idx[SW-1:0]];
  end

endmodule

@@ hw/rtl/tlh_log2.sv @@
// Iterative floor-log2 unit for a 64-bit latency: byte steps, then bit steps.
// Depends on tlh_pkg.
module tlh_log2 (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            go_i,
  input  logic [tlh_pkg::TS_W-1:0]        value_i,
  output logic                            done_o,
  output logic [tlh_pkg::SLOT_MAX_W-1:0]  lg_o
);
  import tlh_pkg::*;

  logic                  busy_q;
  logic [TS_W-1:0]       v_q;
  logic [SLOT_MAX_W-1:0] r_q;

  assign done_o = busy_q && (v_q[TS_W-1:1] == '0);
  assign lg_o   = r_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      v_q    <= '0;
      r_q    <= '0;
    end else if (go_i) begin
      busy_q <= 1'b1;
      v_q    <= value_i;
      r_q    <= '0;
    end else if (busy_q) begin
      if (v_q[TS_W-1:8] != '0) begin
        v_q <= v_q >> 8;
        r_q <= r_q + SLOT_MAX_W'(8);
      end else if (v_q[7:1] != '0) begin
        v_q <= v_q >> 1;
        r_q <= r_q + 1'b1;
      end else begin
        busy_q <= 1'b0;
      end
    end
  end

endmodule

@@ hw/rtl/task_latency_histogram_top.sv @@
// Task latency histogram top: command sequencer, config registers, output register.
// Flow: start/end scan the task table; an end that hits goes on to a threshold check,
// and when binned to the log2 unit (the slot read overlaps its last step) and a
// write-back; a read does a slot read, then reports; filtered-out and unused commands
// report straight from idle. One command at a time; results cannot be held off.
// Reset (async, active low) clears table and slot valid flops at once; no sweep.
// Depends on tlh_pkg, tlh_table, tlh_hist, tlh_log2.
module task_latency_histogram_top #(
  parameter int unsigned TABLE_ENTRIES = 256,
  parameter int unsigned HIST_SLOTS    = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  tlh_pkg::in_t  in_i,
  output logic          strobe_o,
  output tlh_pkg::out_t out_o,
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic [1:0]    cfg_index_i,
  input  logic [31:0]   cfg_data_i
);
  import tlh_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_SRCH, S_CHK, S_LOG, S_HW, S_RDW} state_e;

  state_e          state_q;
  in_t             item_q;
  out_t            res_q;
  logic            strobe_q;
  logic [TS_W-1:0] lat_q;
  logic [IDX_MAX_W-1:0]  e_q;
  logic [SLOT_MAX_W-1:0] slot_q;
  logic [ID_W-1:0] fg_q;
  logic [ID_W-1:0] ft_q;
  logic [31:0]     thr_q;

  tab_req_t   tab_req;
  tab_wr_t    tab_wr;
  tab_resp_t  tab_resp;
  hist_req_t  hist_req;
  hist_resp_t hist_resp;
  logic       log_go;
  logic       log_done;
  logic [SLOT_MAX_W-1:0] log_lg;
  logic [SLOT_MAX_W-1:0] slot_sat;

  logic accept;
  logic pass_in;
  logic lat_ok;
  logic sel_ok;
  logic no_filter;

  assign accept      = start && !busy;
  assign busy        = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign strobe_o    = strobe_q;
  assign out_o       = res_q;

  assign pass_in   = ((fg_q == '0) || (in_i.group_id == fg_q)) &&
                     ((ft_q == '0) || (in_i.task_id == ft_q));
  assign lat_ok    = !lat_q[TS_W-1] && (lat_q >= {32'd0, thr_q});
  assign sel_ok    = ({2'b00, item_q.slot_select} < 7'(HIST_SLOTS));
  assign no_filter = (fg_q == '0) && (ft_q == '0);
  assign slot_sat  = ({1'b0, log_lg} >= 7'(HIST_SLOTS)) ? SLOT_MAX_W'(HIST_SLOTS - 1) : log_lg;

  always_comb begin
    tab_req.go  = accept && ((in_i.opcode == OP_START) || (in_i.opcode == OP_END)) && pass_in;
    tab_req.key = {in_i.group_id, in_i.task_id};

    tab_wr.we  = (state_q == S_SRCH) && tab_resp.done && (item_q.opcode == OP_START) &&
                 (tab_resp.hit || tab_resp.free_ok);
    tab_wr.clr = (state_q == S_HW) && no_filter;
    tab_wr.idx = (state_q == S_HW) ? e_q : tab_resp.idx;
    tab_wr.key = {item_q.group_id, item_q.task_id};
    tab_wr.ns  = item_q.now_ns;

    log_go = (state_q == S_CHK) && lat_ok;

    hist_req.rd_en  = (accept && (in_i.opcode == OP_READ)) || ((state_q == S_LOG) && log_done);
    hist_req.rd_idx = (state_q == S_LOG) ? slot_sat : SLOT_MAX_W'(in_i.slot_select);
    hist_req.we     = (state_q == S_HW);
    hist_req.wr_idx = slot_q;
    hist_req.hits   = hist_resp.hits + 32'd1;
    hist_req.sum    = hist_resp.sum + lat_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fg_q  <= '0;
      ft_q  <= '0;
      thr_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_GROUP:  fg_q  <= cfg_data_i[ID_W-1:0];
        CFG_TASK:   ft_q  <= cfg_data_i[ID_W-1:0];
        CFG_THRESH: thr_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      strobe_q <= 1'b0;
      res_q    <= '0;
      item_q   <= '0;
      lat_q    <= '0;
      e_q      <= '0;
      slot_q   <= '0;
    end else begin
      strobe_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            item_q <= in_i;
            res_q  <= '0;
            if (tab_req.go) begin
              state_q <= S_SRCH;
            end else if (in_i.opcode == OP_READ) begin
              state_q <= S_RDW;
            end else begin
              strobe_q <= 1'b1;
            end
          end
        end
        S_SRCH: begin
          if (tab_resp.done) begin
            if ((item_q.opcode == OP_END) && tab_resp.hit) begin
              lat_q   <= item_q.now_ns - tab_resp.start_ns;
              e_q     <= tab_resp.idx;
              state_q <= S_CHK;
            end else begin
              strobe_q <= 1'b1;
              state_q  <= S_IDLE;
            end
          end
        end
        S_CHK: begin
          if (lat_ok) begin
            state_q <= S_LOG;
          end else begin
            strobe_q <= 1'b1;
            state_q  <= S_IDLE;
          end
        end
        S_LOG: begin
          if (log_done) begin
            slot_q  <= slot_sat;
            state_q <= S_HW;
          end
        end
        S_HW: begin
          if (thr_q != '0) begin
            res_q.report_kind    <= KIND_EVENT;
            res_q.report_task    <= item_q.task_id;
            res_q.report_end_ns  <= item_q.now_ns;
            res_q.report_latency <= lat_q;
          end
          strobe_q <= 1'b1;
          state_q  <= S_IDLE;
        end
        S_RDW: begin
          res_q.report_kind <= KIND_SLOT;
          if (sel_ok) begin
            res_q.slot_hits   <= hist_resp.hits;
            res_q.slot_sum_ns <= hist_resp.sum;
          end
          strobe_q <= 1'b1;
          state_q  <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  tlh_table #(.ENTRIES(TABLE_ENTRIES)) u_table (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (tab_req),
    .wr_i   (tab_wr),
    .resp_o (tab_resp)
  );

  tlh_hist #(.SLOTS(HIST_SLOTS)) u_hist (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (hist_req),
    .resp_o (hist_resp)
  );

  tlh_log2 u_log2 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .go_i    (log_go),
    .value_i (lat_q),
    .done_o  (log_done),
    .lg_o    (log_lg)
  );

`ifndef NO_ASSERTIONS
  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (busy || strobe_o))
    else $error("accepted transaction neither in progress nor reported");
  a_event_needs_thr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_o && (out_o.report_kind == KIND_EVENT)) |-> (thr_q != '0))
    else $error("latency event reported with zero threshold");
  a_no_bad_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |-> (out_o.report_kind != KIND_BAD))
    else $error("invalid report kind");
  a_hist_wr_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hist_req.we |-> !lat_q[TS_W-1])
    else $error("negative latency binned");
`endif

endmodule
